// ----- rtl/core/lct_pkg.sv -----
// lct_pkg: shared types and constants for the LBA to CHS translate/check block.
// Used by lba_chs_translate_check and lct_div; depends on nothing else.
package lct_pkg;

    localparam int LBA_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int HEADS_W      = 9;
    localparam int SPT_W        = 6;
    localparam int PACK_CYL_W   = 10;     // cylinder bits that fit the packed MBR triple
    localparam int CHK_PROD_W   = 26;     // (c * heads + head) * spt, full range
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 9;
    localparam int DIV_STEPS    = 4;      // restoring steps per divider stage

    localparam int MAX_CYLINDERS_DEF = 1024;

    localparam logic [HEADS_W-1:0] HEADS_RESET = HEADS_W'(16);
    localparam logic [SPT_W-1:0]   SPT_RESET   = SPT_W'(63);

    localparam logic [BYTE_W-1:0] CHS_MARKER   = 8'hFF;
    localparam logic [BYTE_W-1:0] SEC_CYL_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] SEC_NUM_MASK = 8'h3F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADS_COUNT       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = CFG_IDX_W'(1);

    // request kinds
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [LBA_W-1:0]  lba;
        logic [BYTE_W-1:0] cyl_low_in;
        logic [BYTE_W-1:0] head_in;
        logic [BYTE_W-1:0] sector_in;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] cyl_low_out;
        logic [BYTE_W-1:0] head_out;
        logic [BYTE_W-1:0] sector_out;
        logic              beyond_limit;
        logic              chs_mismatch;
    } t_rsp;

    // per-request flags that ride along the divider pipelines
    typedef struct packed {
        logic kind;
        logic beyond;
        logic mism;
    } t_tag;

endpackage

// ----- rtl/core/lba_chs_translate_check.sv -----
// lba_chs_translate_check: LBA to packed MBR CHS encoder and CHS checker.
// Top level; uses lct_pkg and two lct_div pipelines (lba/spt, track/heads).
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | receive   | i_in_valid / o_in_stall  | i_in_data  (t_req)
//  out     | send      | o_out_valid / i_out_stall| o_out_data (t_rsp)
//  cfg     | receive   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_stall is low. Requests pass the request register, the
// limit compare, multiply and check compare stages, then the two divider pipelines, into the output buffer.
// Reset sets heads to 16, sectors per track to 63, clears all valid bits and empties
// the two-entry output buffer. The pipeline moves as a whole and freezes only when
// both output buffer entries are held; o_in_stall is high exactly then.
module lba_chs_translate_check
    import lct_pkg::*;
#(
    parameter int MAX_CYLINDERS = MAX_CYLINDERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_req                  i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_rsp                  o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CYL_W  = (MAX_CYLINDERS >= 4) ? $clog2(MAX_CYLINDERS) : 2;
    localparam int TRK_W  = HEADS_W + CYL_W;          // track number below limit
    localparam int NUM1_W = SPT_W + TRK_W;            // lba bits needed below limit
    localparam int LIM_W  = HEADS_W + SPT_W + CYL_W + 1;
    localparam int SIDE1_W = $bits(t_tag);
    localparam int SIDE2_W = $bits(t_tag) + SPT_W;

    // ---------------- configuration ----------------
    logic [HEADS_W-1:0] r_heads;
    logic [SPT_W-1:0]   r_spt;
    logic [LIM_W-1:0]   r_limit;
    logic [HEADS_W-1:0] w_eff_h;
    logic [SPT_W-1:0]   w_eff_s;
    logic               w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_eff_h     = (r_heads == '0) ? HEADS_W'(1) : r_heads;
    assign w_eff_s     = (r_spt == '0) ? SPT_W'(1) : r_spt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads <= HEADS_RESET;
            r_spt   <= SPT_RESET;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                REG_HEADS_COUNT:       r_heads <= i_cfg_data[HEADS_W-1:0];
                REG_SECTORS_PER_TRACK: r_spt   <= i_cfg_data[SPT_W-1:0];
                default: ;
            endcase
        end
    end

    // limit is registered from the geometry and follows it in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(HEADS_RESET * SPT_RESET * MAX_CYLINDERS);
        end else begin
            r_limit <= LIM_W'(w_eff_h * w_eff_s * MAX_CYLINDERS);
        end
    end

    // ---------------- flow control ----------------
    logic [1:0] r_cnt;
    logic       w_adv;

    assign w_adv      = (r_cnt != 2'd2);
    assign o_in_stall = !w_adv;

    // ---------------- stage 0: request register ----------------
    logic r_s0_v;
    t_req r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_adv) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= i_in_data;
        end
    end

    // ---------------- stage 1: limit compare, cylinder * heads ----------------
    logic [PACK_CYL_W-1:0]         w_cyl_in;
    logic [PACK_CYL_W+HEADS_W-1:0] w_cm;
    logic                          w_beyond;
    logic                          r_s1_v;
    t_req                          r_s1;
    logic                          r_s1_beyond;
    logic [PACK_CYL_W+HEADS_W-1:0] r_s1_cm;

    assign w_cyl_in = {r_s0.sector_in[BYTE_W-1:BYTE_W-2], r_s0.cyl_low_in};
    assign w_cm     = (PACK_CYL_W + HEADS_W)'(w_cyl_in * w_eff_h);
    assign w_beyond = (r_s0.lba >= LBA_W'(r_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1        <= r_s0;
            r_s1_beyond <= w_beyond;
            r_s1_cm     <= w_cm;
        end
    end

    // ---------------- stage 2: (c * heads + head) * spt ----------------
    logic [PACK_CYL_W+HEADS_W:0] w_th;
    logic [CHK_PROD_W-1:0]       w_x;
    logic                        r_s2_v;
    t_req                        r_s2;
    logic                        r_s2_beyond;
    logic [CHK_PROD_W-1:0]       r_s2_x;

    assign w_th = (PACK_CYL_W + HEADS_W + 1)'(r_s1_cm) + (PACK_CYL_W + HEADS_W + 1)'(r_s1.head_in);
    assign w_x  = CHK_PROD_W'(w_th * w_eff_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2        <= r_s1;
            r_s2_beyond <= r_s1_beyond;
            r_s2_x      <= w_x;
        end
    end

    // ---------------- stage 3: check compare ----------------
    logic [SPT_W-1:0]    w_sec_in;
    logic [CHK_PROD_W:0] w_xs;
    logic                w_marker;
    logic                w_mism;
    t_tag                w_tag3;
    logic                r_s3_v;
    t_tag                r_s3_tag;
    logic [NUM1_W-1:0]   r_s3_num;

    assign w_sec_in = r_s2.sector_in[SPT_W-1:0];
    assign w_xs     = (CHK_PROD_W + 1)'(r_s2_x) + (CHK_PROD_W + 1)'(w_sec_in)
                      - (CHK_PROD_W + 1)'(1);
    assign w_marker = (r_s2.cyl_low_in == CHS_MARKER) && (r_s2.head_in == CHS_MARKER)
                      && (r_s2.sector_in == CHS_MARKER);
    // sector zero is invalid on its own; then the rebuilt address is ignored
    assign w_mism   = (r_s2.kind == KIND_CHECK) && !r_s2_beyond && !w_marker
                      && ((w_sec_in == '0) || (LBA_W'(w_xs) != r_s2.lba));

    always_comb begin
        w_tag3.kind   = r_s2.kind;
        w_tag3.beyond = r_s2_beyond;
        w_tag3.mism   = w_mism;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_adv) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_tag <= w_tag3;
            r_s3_num <= r_s2.lba[NUM1_W-1:0];
        end
    end

    // ---------------- lba / spt ----------------
    logic               w_d1_v;
    logic [TRK_W-1:0]   w_d1_quo;
    logic [SPT_W-1:0]   w_d1_rem;
    logic [SIDE1_W-1:0] w_d1_side;
    logic [SPT_W-1:0]   w_sector;

    lct_div #(
        .DEN_W  (SPT_W),
        .QUO_W  (TRK_W),
        .STEPS  (DIV_STEPS),
        .SIDE_W (SIDE1_W)
    ) u_div_spt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s3_v),
        .i_num   (r_s3_num),
        .i_den   (w_eff_s),
        .i_side  (r_s3_tag),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_quo),
        .o_rem   (w_d1_rem),
        .o_side  (w_d1_side)
    );

    assign w_sector = SPT_W'(w_d1_rem + SPT_W'(1));

    // ---------------- track / heads ----------------
    logic               w_d2_v;
    logic [CYL_W-1:0]   w_d2_quo;
    logic [HEADS_W-1:0] w_d2_rem;
    logic [SIDE2_W-1:0] w_d2_side;

    lct_div #(
        .DEN_W  (HEADS_W),
        .QUO_W  (CYL_W),
        .STEPS  (DIV_STEPS),
        .SIDE_W (SIDE2_W)
    ) u_div_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_d1_v),
        .i_num   (w_d1_quo),
        .i_den   (w_eff_h),
        .i_side  ({w_d1_side, w_sector}),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_quo),
        .o_rem   (w_d2_rem),
        .o_side  (w_d2_side)
    );

    // ---------------- result assembly ----------------
    t_tag                  w_tag_o;
    logic [SPT_W-1:0]      w_sec_o;
    logic [PACK_CYL_W-1:0] w_cyl_o;
    t_rsp                  w_rsp;

    assign w_tag_o = t_tag'(w_d2_side[SIDE2_W-1:SPT_W]);
    assign w_sec_o = w_d2_side[SPT_W-1:0];
    assign w_cyl_o = PACK_CYL_W'(w_d2_quo);

    always_comb begin
        w_rsp              = '0;
        w_rsp.beyond_limit = w_tag_o.beyond;
        w_rsp.chs_mismatch = w_tag_o.mism;
        if (w_tag_o.kind == KIND_ENCODE) begin
            if (w_tag_o.beyond) begin
                w_rsp.cyl_low_out = CHS_MARKER;
                w_rsp.head_out    = CHS_MARKER;
                w_rsp.sector_out  = CHS_MARKER;
            end else begin
                w_rsp.cyl_low_out = w_cyl_o[BYTE_W-1:0];
                w_rsp.head_out    = w_d2_rem[BYTE_W-1:0];
                w_rsp.sector_out  = {w_cyl_o[PACK_CYL_W-1:BYTE_W], w_sec_o};
            end
        end
    end

    // ---------------- two-entry output buffer ----------------
    logic w_push;
    logic w_pop;
    t_rsp r_q0;
    t_rsp r_q1;

    assign w_push = w_d2_v && w_adv;
    assign w_pop  = (r_cnt != 2'd0) && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            if ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop)) begin
                r_q0 <= w_rsp;
            end else begin
                r_q1 <= w_rsp;
            end
        end
        if (w_pop && (r_cnt == 2'd2)) begin
            r_q0 <= r_q1;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    // ---------------- assertions ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && $past(o_out_valid)))
        else $error("input stalled without a held result");

    a_beyond_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.beyond_limit && o_out_data.chs_mismatch))
        else $error("mismatch flagged beyond the limit");

    a_sector_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.beyond_limit
            && (o_out_data.sector_out[SPT_W-1:0] == '0))
        |-> ((o_out_data.cyl_low_out == '0) && (o_out_data.head_out == '0)
            && (o_out_data.sector_out == '0)))
        else $error("encoded sector of zero");

endmodule

// ----- rtl/core/lct_div.sv -----
// lct_div: pipelined restoring divider, DIV_STEPS quotient bits per stage.
// Carries a valid bit and a sideband vector with each request. Uses lct_pkg.
module lct_div
    import lct_pkg::*;
#(
    parameter int DEN_W  = SPT_W,
    parameter int QUO_W  = 19,
    parameter int STEPS  = DIV_STEPS,
    parameter int SIDE_W = $bits(t_tag)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [DEN_W+QUO_W-1:0] i_num,
    input  logic [DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo,
    output logic [DEN_W-1:0]       o_rem,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int NST = (QUO_W + STEPS - 1) / STEPS;

    // Dividend must be below den * 2**QUO_W: the top DEN_W bits then start as
    // a valid partial remainder. r_w holds unused dividend bits on top and
    // quotient bits shifting in from the bottom.
    logic              r_v    [NST];
    logic [DEN_W-1:0]  r_rem  [NST];
    logic [QUO_W-1:0]  r_w    [NST];
    logic [SIDE_W-1:0] r_side [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        localparam int NSTEP = (QUO_W - g * STEPS < STEPS) ? (QUO_W - g * STEPS) : STEPS;

        logic              w_v_in;
        logic [DEN_W-1:0]  w_rem_in;
        logic [QUO_W-1:0]  w_w_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [DEN_W:0]    w_t;
        logic [DEN_W-1:0]  n_rem;
        logic [QUO_W-1:0]  n_w;

        if (g == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = i_num[DEN_W+QUO_W-1:QUO_W];
            assign w_w_in    = i_num[QUO_W-1:0];
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_w_in    = r_w[g-1];
            assign w_side_in = r_side[g-1];
        end

        always_comb begin
            n_rem = w_rem_in;
            n_w   = w_w_in;
            w_t   = '0;
            for (int k = 0; k < NSTEP; k++) begin
                w_t = {n_rem, n_w[QUO_W-1]};
                if (w_t >= {1'b0, i_den}) begin
                    n_rem = DEN_W'(w_t - {1'b0, i_den});
                    n_w   = {n_w[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_t[DEN_W-1:0];
                    n_w   = {n_w[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_w[g]    <= n_w;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_quo   = r_w[NST-1];
    assign o_rem   = r_rem[NST-1];
    assign o_side  = r_side[NST-1];

endmodule
